// ===== rtl/rmq_pkg.sv =====
// rmq_pkg: shared types for the rotation matrix to quaternion pipeline
// no dependencies; used by the front stage, the cells and the top level
package rmq_pkg;

  localparam int DATA_W = 16;
  localparam int MAG_W  = 17;   // magnitude of a sum or difference of two entries

  // output slot: 0 = w, 1 = x, 2 = y, 3 = z
  typedef logic [1:0] slot_t;

  localparam slot_t SLOT_W = 2'd0;
  localparam slot_t SLOT_X = 2'd1;
  localparam slot_t SLOT_Y = 2'd2;
  localparam slot_t SLOT_Z = 2'd3;

  // control that travels alongside the data through every stage
  typedef struct packed {
    logic             valid;
    logic             degen;
    slot_t            hslot;   // where the half root goes
    slot_t [2:0]      lslot;   // where each quotient lane goes
    logic  [2:0]      neg;     // sign of each lane numerator
  } rmq_ctrl_t;

endpackage

// ===== rtl/rmq_if.sv =====
// rmq_in_if / rmq_out_if: valid-ready channels for matrices and quaternions
// depends on rmq_pkg for the field width
interface rmq_in_if import rmq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_out_if import rmq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] qw, qx, qy, qz;
  logic                     degenerate;

  modport source (output valid, qw, qx, qy, qz, degenerate, input ready);
  modport sink   (input valid, qw, qx, qy, qz, degenerate, output ready);
endinterface

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Rotation matrix to unit quaternion. One matrix enters per clock and one
// result leaves per clock while the output is not stalled. The front stage
// is followed by a chain of RW square-root cells, one root bit each, and a
// chain of DIV_W divider cells, one quotient bit each for three lanes (RW =
// root bits, DIV_W = quotient bits; 16 and 32 at FRAC_BITS = 14), then the
// output register. A stalled output freezes the whole chain.
// depends on rmq_pkg, rmq_if, rmq_front, rmq_sqrt_cell, rmq_div_cell
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);

  localparam int ARG_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int RAD_W0 = ARG_W + FRAC_BITS;
  localparam int RAD_W  = RAD_W0 + (RAD_W0 % 2);
  localparam int RW     = RAD_W / 2;
  localparam int DIV_W  = MAG_W + FRAC_BITS + 1;
  localparam int ONE    = 1 << FRAC_BITS;
  localparam int LIM_P  = (ONE > 32767) ? 32767 : ONE;
  localparam int LIM_N  = (ONE > 32768) ? 32768 : ONE;

  logic en;

  rmq_ctrl_t             sq_ctrl [RW+1];
  logic [RAD_W-1:0]      sq_rad  [RW+1];
  logic [RW+1:0]         sq_rem  [RW+1];
  logic [RW-1:0]         sq_root [RW+1];
  logic [2:0][MAG_W-1:0] sq_mag  [RW+1];

  rmq_ctrl_t             dv_ctrl [DIV_W+1];
  logic [RW-1:0]         dv_root [DIV_W+1];
  logic [2:0][DIV_W-1:0] dv_dvd  [DIV_W+1];
  logic [2:0][RW+1:0]    dv_rem  [DIV_W+1];

  logic                     out_valid_q;
  logic                     degen_q;
  logic signed [DATA_W-1:0] q_q [4];
  logic signed [DATA_W-1:0] q_d [4];
  logic signed [DATA_W-1:0] lane_v [3];
  logic signed [DATA_W-1:0] half_v;
  logic [RW:0]              half;
  logic [DIV_W-1:0]         qmag;
  logic signed [DATA_W:0]   sv;
  rmq_ctrl_t                fin;

  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W), .RAD_W(RAD_W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .m00_i   (in_i.m00), .m01_i (in_i.m01), .m02_i (in_i.m02),
    .m10_i   (in_i.m10), .m11_i (in_i.m11), .m12_i (in_i.m12),
    .m20_i   (in_i.m20), .m21_i (in_i.m21), .m22_i (in_i.m22),
    .ctrl_o  (sq_ctrl[0]),
    .rad_o   (sq_rad[0]),
    .mag_o   (sq_mag[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar s = 0; s < RW; s++) begin : g_sqrt
    rmq_sqrt_cell #(.RAD_W(RAD_W), .RW(RW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (sq_ctrl[s]),
      .rad_i  (sq_rad[s]),
      .rem_i  (sq_rem[s]),
      .root_i (sq_root[s]),
      .mag_i  (sq_mag[s]),
      .ctrl_o (sq_ctrl[s+1]),
      .rad_o  (sq_rad[s+1]),
      .rem_o  (sq_rem[s+1]),
      .root_o (sq_root[s+1]),
      .mag_o  (sq_mag[s+1])
    );
  end

  // dividend is mag * 2^frac + root, which rounds the quotient by 2*root
  assign dv_ctrl[0] = sq_ctrl[RW];
  assign dv_root[0] = sq_root[RW];
  assign dv_rem[0]  = '0;
  for (genvar l = 0; l < 3; l++) begin : g_dvd
    assign dv_dvd[0][l] = (DIV_W'(sq_mag[RW][l]) << FRAC_BITS) + DIV_W'(sq_root[RW]);
  end

  for (genvar s = 0; s < DIV_W; s++) begin : g_div
    rmq_div_cell #(.RW(RW), .DIV_W(DIV_W)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (dv_ctrl[s]),
      .root_i (dv_root[s]),
      .dvd_i  (dv_dvd[s]),
      .rem_i  (dv_rem[s]),
      .ctrl_o (dv_ctrl[s+1]),
      .root_o (dv_root[s+1]),
      .dvd_o  (dv_dvd[s+1]),
      .rem_o  (dv_rem[s+1])
    );
  end

  always_comb begin
    fin  = dv_ctrl[DIV_W];
    half = ({1'b0, dv_root[DIV_W]} + (RW+1)'(1)) >> 1;
    half_v = (half > (RW+1)'(LIM_P)) ? DATA_W'(LIM_P) : DATA_W'(half);
    for (int l = 0; l < 3; l++) begin
      qmag = dv_dvd[DIV_W][l];
      if (fin.neg[l]) begin
        sv = (qmag > DIV_W'(LIM_N)) ? -(DATA_W+1)'(LIM_N) : -(DATA_W+1)'(qmag);
      end else begin
        sv = (qmag > DIV_W'(LIM_P)) ? (DATA_W+1)'(LIM_P) : (DATA_W+1)'(qmag);
      end
      lane_v[l] = sv[DATA_W-1:0];
    end
    for (int t = 0; t < 4; t++) begin
      q_d[t] = '0;
    end
    if (!fin.degen) begin
      q_d[fin.hslot] = half_v;
      for (int l = 0; l < 3; l++) begin
        q_d[fin.lslot[l]] = lane_v[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degen_q <= fin.degen;
      for (int t = 0; t < 4; t++) begin
        q_q[t] <= q_d[t];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.degenerate = degen_q;
  assign out_o.qw         = q_q[0];
  assign out_o.qx         = q_q[1];
  assign out_o.qy         = q_q[2];
  assign out_o.qz         = q_q[3];

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && degen_q |-> (q_q[0] == 0) && (q_q[1] == 0) &&
                               (q_q[2] == 0) && (q_q[3] == 0))
    else $error("degenerate result with nonzero component");

  a_nondegen_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !degen_q |-> (q_q[0] != 0) || (q_q[1] != 0) ||
                                (q_q[2] != 0) || (q_q[3] != 0))
    else $error("regular result lost its half root");

  a_half_positive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.valid && !fin.degen |-> half_v > 0)
    else $error("half root not positive");

  a_stall_freezes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("request taken while result stalled");

endmodule

// ===== rtl/rmq_front.sv =====
// rmq_front: first stage, picks the branch, forms the radicand and numerators
// depends on rmq_pkg
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = 14,
  parameter int ARG_W     = 18,
  parameter int RAD_W     = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [DATA_W-1:0] m00_i, m01_i, m02_i,
  input  logic signed [DATA_W-1:0] m10_i, m11_i, m12_i,
  input  logic signed [DATA_W-1:0] m20_i, m21_i, m22_i,
  output rmq_ctrl_t                ctrl_o,
  output logic [RAD_W-1:0]         rad_o,
  output logic [2:0][MAG_W-1:0]    mag_o
);

  localparam int SW = ARG_W + 2;
  localparam int NW = MAG_W + 1;

  logic signed [SW-1:0] d0, d1, d2, one_s, trace, arg;
  logic signed [NW-1:0] e01, e02, e10, e12, e20, e21;
  logic signed [NW-1:0] num [3];
  logic [1:0]           sel;
  rmq_ctrl_t            ctrl_d, ctrl_q;
  logic [RAD_W-1:0]     rad_d, rad_q;
  logic [2:0][MAG_W-1:0] mag_d, mag_q;
  logic                 tpos;

  always_comb begin
    d0    = SW'(m00_i);
    d1    = SW'(m11_i);
    d2    = SW'(m22_i);
    e01   = NW'(m01_i);
    e02   = NW'(m02_i);
    e10   = NW'(m10_i);
    e12   = NW'(m12_i);
    e20   = NW'(m20_i);
    e21   = NW'(m21_i);
    one_s = SW'(1) <<< FRAC_BITS;
    trace = d0 + d1 + d2;
    tpos  = trace > 0;
    // largest diagonal entry, ties keep the lower index
    sel = 2'd0;
    if (m11_i > m00_i) sel = 2'd1;
    if (sel == 2'd1) begin
      if (m22_i > m11_i) sel = 2'd2;
    end else begin
      if (m22_i > m00_i) sel = 2'd2;
    end

    ctrl_d       = '0;
    ctrl_d.valid = valid_i;
    if (tpos) begin
      arg    = trace + one_s;
      num[0] = e21 - e12;
      num[1] = e02 - e20;
      num[2] = e10 - e01;
      ctrl_d.hslot = SLOT_W;
      ctrl_d.lslot = {SLOT_Z, SLOT_Y, SLOT_X};
    end else begin
      unique case (sel)
        2'd1: begin
          arg    = d1 - d2 - d0 + one_s;
          num[0] = e02 - e20;
          num[1] = e21 + e12;
          num[2] = e01 + e10;
          ctrl_d.hslot = SLOT_Y;
          ctrl_d.lslot = {SLOT_X, SLOT_Z, SLOT_W};
        end
        2'd2: begin
          arg    = d2 - d0 - d1 + one_s;
          num[0] = e10 - e01;
          num[1] = e02 + e20;
          num[2] = e12 + e21;
          ctrl_d.hslot = SLOT_Z;
          ctrl_d.lslot = {SLOT_Y, SLOT_X, SLOT_W};
        end
        default: begin
          arg    = d0 - d1 - d2 + one_s;
          num[0] = e21 - e12;
          num[1] = e10 + e01;
          num[2] = e20 + e02;
          ctrl_d.hslot = SLOT_X;
          ctrl_d.lslot = {SLOT_Z, SLOT_Y, SLOT_W};
        end
      endcase
    end
    ctrl_d.degen = !(arg > 0);
    rad_d = ctrl_d.degen ? '0 : (RAD_W'(arg[ARG_W-1:0]) << FRAC_BITS);
    for (int l = 0; l < 3; l++) begin
      ctrl_d.neg[l] = num[l][NW-1];
      mag_d[l]      = num[l][NW-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q <= rad_d;
      mag_q <= mag_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rad_o  = rad_q;
  assign mag_o  = mag_q;

endmodule

// ===== rtl/rmq_sqrt_cell.sv =====
// rmq_sqrt_cell: one root bit of the restoring square root per cell
// depends on rmq_pkg
module rmq_sqrt_cell import rmq_pkg::*; #(
  parameter int RAD_W = 32,
  parameter int RW    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  rmq_ctrl_t             ctrl_i,
  input  logic [RAD_W-1:0]      rad_i,
  input  logic [RW+1:0]         rem_i,
  input  logic [RW-1:0]         root_i,
  input  logic [2:0][MAG_W-1:0] mag_i,
  output rmq_ctrl_t             ctrl_o,
  output logic [RAD_W-1:0]      rad_o,
  output logic [RW+1:0]         rem_o,
  output logic [RW-1:0]         root_o,
  output logic [2:0][MAG_W-1:0] mag_o
);

  rmq_ctrl_t             ctrl_q;
  logic [RAD_W-1:0]      rad_q;
  logic [RW+1:0]         rem_q, rem_d, rem_sh, trial;
  logic [RW-1:0]         root_q, root_d;
  logic [2:0][MAG_W-1:0] mag_q;

  always_comb begin
    rem_sh = {rem_i[RW-1:0], rad_i[RAD_W-1 -: 2]};
    trial  = {root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[RW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_i << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
      mag_q  <= mag_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign mag_o  = mag_q;

endmodule

// ===== rtl/rmq_div_cell.sv =====
// rmq_div_cell: one quotient bit for each of three lanes by 2*root
// depends on rmq_pkg
module rmq_div_cell import rmq_pkg::*; #(
  parameter int RW    = 16,
  parameter int DIV_W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  rmq_ctrl_t             ctrl_i,
  input  logic [RW-1:0]         root_i,
  input  logic [2:0][DIV_W-1:0] dvd_i,
  input  logic [2:0][RW+1:0]    rem_i,
  output rmq_ctrl_t             ctrl_o,
  output logic [RW-1:0]         root_o,
  output logic [2:0][DIV_W-1:0] dvd_o,
  output logic [2:0][RW+1:0]    rem_o
);

  rmq_ctrl_t             ctrl_q;
  logic [RW-1:0]         root_q;
  logic [2:0][DIV_W-1:0] dvd_q, dvd_d;
  logic [2:0][RW+1:0]    rem_q, rem_d;
  logic [RW+1:0]         den, rem_sh;

  always_comb begin
    den = {1'b0, root_i, 1'b0};
    for (int l = 0; l < 3; l++) begin
      rem_sh = {rem_i[l][RW:0], dvd_i[l][DIV_W-1]};
      // quotient bit shifts into the vacated dividend bit
      if (rem_sh >= den) begin
        rem_d[l] = rem_sh - den;
        dvd_d[l] = {dvd_i[l][DIV_W-2:0], 1'b1};
      end else begin
        rem_d[l] = rem_sh;
        dvd_d[l] = {dvd_i[l][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_i;
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign root_o = root_q;
  assign dvd_o  = dvd_q;
  assign rem_o  = rem_q;

endmodule

// ===== tb/sv/rotation_matrix_to_quaternion_tb.sv =====
// rotation_matrix_to_quaternion_tb: checks the matrix to quaternion pipeline
// against a fixed-point predictor, with random bursts and output stalls
// depends on rmq_pkg, rmq_if and rotation_matrix_to_quaternion
module rotation_matrix_to_quaternion_tb import rmq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int N_RANDOM = 1030;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef fx_t mat_t [9];

  typedef struct {
    fx_t  qw, qx, qy, qz;
    logic degen;
  } quat_t;

  typedef struct {
    mat_t  m;
    logic  known;   // expected value typed in the table
    quat_t q;
  } vec_t;

  logic clk_i;
  logic rst_ni;
  rmq_in_if  in_if ();
  rmq_out_if out_if ();

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  quat_t  quat_fifo[$];
  int     n_errors;
  int     n_checked;
  int     n_degen;
  longint cycles;
  bit     stim_done;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // num * 2^frac / (2*root), rounded half away from zero
  function automatic longint half_ratio(longint num, longint unsigned root);
    longint unsigned den, mag, q;
    den = root << 1;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = ((mag << FRAC) + (den >> 1)) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic fx_t clamp_unit(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    return fx_t'(v);
  endfunction

  function automatic quat_t matrix_to_quat(mat_t mi);
    longint m[3][3];
    longint q[4];
    longint trace, arg;
    longint unsigned root;
    int a, b, c;
    quat_t r;
    for (int i = 0; i < 9; i++) m[i / 3][i % 3] = longint'(mi[i]);
    q = '{0, 0, 0, 0};
    r.degen = 1'b0;
    trace = m[0][0] + m[1][1] + m[2][2];
    if (trace > 0) begin
      root = int_sqrt(longint'(trace + ONE) << FRAC);
      q[0] = longint'((root + 1) >> 1);
      q[1] = half_ratio(m[2][1] - m[1][2], root);
      q[2] = half_ratio(m[0][2] - m[2][0], root);
      q[3] = half_ratio(m[1][0] - m[0][1], root);
    end else begin
      // largest diagonal, ties keep the lower index
      a = 0;
      if (m[1][1] > m[0][0]) a = 1;
      if (m[2][2] > m[a][a]) a = 2;
      b = (a + 1) % 3;
      c = (b + 1) % 3;
      arg = m[a][a] - m[b][b] - m[c][c] + ONE;
      if (arg <= 0) begin
        r.degen = 1'b1;
      end else begin
        root = int_sqrt(longint'(arg) << FRAC);
        q[1 + a] = longint'((root + 1) >> 1);
        q[0] = half_ratio(m[c][b] - m[b][c], root);
        q[1 + b] = half_ratio(m[b][a] + m[a][b], root);
        q[1 + c] = half_ratio(m[c][a] + m[a][c], root);
      end
    end
    r.qw = clamp_unit(q[0]);
    r.qx = clamp_unit(q[1]);
    r.qy = clamp_unit(q[2]);
    r.qz = clamp_unit(q[3]);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch @%0t %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // random matrix: mostly in range, sometimes full 16-bit patterns
  function automatic mat_t random_matrix();
    mat_t m;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (mode == 0)
        m[i] = fx_t'($urandom());
      else if (mode == 1)
        m[i] = $urandom_range(0, 3) == 0 ? fx_t'(ONE) : -fx_t'(ONE);
      else
        m[i] = fx_t'(int'($urandom_range(0, 32768)) - 16384);
    end
    // shape the diagonal to steer trace sign and pivot choice
    if (mode >= 6) begin
      m[0] = fx_t'(int'($urandom_range(0, 32768)) - 16384);
      m[4] = (mode == 7) ? m[0] : fx_t'(-int'($urandom_range(0, 16384)));
      m[8] = (mode == 8) ? m[4] : fx_t'(-int'($urandom_range(0, 16384)));
    end
    return m;
  endfunction

  task automatic send_request(mat_t m);
    in_if.valid <= 1'b1;
    {in_if.m00, in_if.m01, in_if.m02} <= {m[0], m[1], m[2]};
    {in_if.m10, in_if.m11, in_if.m12} <= {m[3], m[4], m[5]};
    {in_if.m20, in_if.m21, in_if.m22} <= {m[6], m[7], m[8]};
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic apply(mat_t m, logic known, quat_t q);
    quat_fifo.push_back(known ? q : matrix_to_quat(m));
    send_request(m);
  endtask

  vec_t   dir_table[$];

  function automatic mat_t diag(fx_t a, fx_t b, fx_t c);
    mat_t m;
    m = '{default: fx_t'(0)};
    m[0] = a;
    m[4] = b;
    m[8] = c;
    return m;
  endfunction

  function automatic quat_t quat(fx_t w, fx_t x, fx_t y, fx_t z, logic d);
    quat_t q;
    q.qw = w; q.qx = x; q.qy = y; q.qz = z; q.degen = d;
    return q;
  endfunction

  initial begin
    mat_t  m;
    quat_t nq;
    int    burst;
    nq = quat(0, 0, 0, 0, 0);
    // identity and half-turns about each axis, zero matrix takes the x pivot
    dir_table.push_back('{diag(16384, 16384, 16384), 1, quat(16384, 0, 0, 0, 0)});
    dir_table.push_back('{diag(16384, -16384, -16384), 1, quat(0, 16384, 0, 0, 0)});
    dir_table.push_back('{diag(-16384, 16384, -16384), 1, quat(0, 0, 16384, 0, 0)});
    dir_table.push_back('{diag(-16384, -16384, 16384), 1, quat(0, 0, 0, 16384, 0)});
    dir_table.push_back('{diag(0, 0, 0), 1, quat(0, 8192, 0, 0, 0)});
    dir_table.push_back('{diag(-16384, -16384, -16384), 0, nq});
    dir_table.push_back('{diag(-32768, -32768, -32768), 0, nq});
    dir_table.push_back('{'{default: fx_t'(32767)}, 0, nq});
    dir_table.push_back('{'{default: fx_t'(-32768)}, 0, nq});
    dir_table.push_back('{'{default: fx_t'(16384)}, 0, nq});
    dir_table.push_back('{'{default: fx_t'(-16384)}, 0, nq});
    dir_table.push_back('{'{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}, 0, nq});
    dir_table.push_back('{'{16384, 0, 0, 0, 0, -16384, 0, 16384, 0}, 0, nq});
    dir_table.push_back('{'{0, 0, 16384, 0, 16384, 0, -16384, 0, 0}, 0, nq});
    dir_table.push_back('{'{1, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0}, 0, nq});
    dir_table.push_back('{diag(1, 0, 0), 0, nq});
    dir_table.push_back('{diag(-1, -1, -1), 0, nq});
    dir_table.push_back('{diag(5000, 5000, -12000), 0, nq});
    dir_table.push_back('{diag(-3000, 7000, 7000), 0, nq});
    dir_table.push_back('{'{-1, 100, -200, 300, -1, 400, -500, 600, -1}, 0, nq});

    in_if.valid <= 1'b0;
    {in_if.m00, in_if.m01, in_if.m02, in_if.m10, in_if.m11} <= '0;
    {in_if.m12, in_if.m20, in_if.m21, in_if.m22} <= '0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_table[i]) begin
      apply(dir_table[i].m, dir_table[i].known, dir_table[i].q);
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        m = random_matrix();
        apply(m, 1'b0, nq);
      end
      idle_gap();
    end
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stalls: long open stretches alternating with choppy ones
  initial begin
    int phase;
    out_if.ready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase = (phase + 1) % 300;
      if (phase < 100) out_if.ready <= 1'b1;
      else if (phase < 200) out_if.ready <= ($urandom_range(0, 3) != 0);
      else out_if.ready <= ($urandom_range(0, 4) == 0) || (phase % 40 < 10);
    end
  end

  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (quat_fifo.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        e = quat_fifo.pop_front();
        n_checked++;
        if (e.degen) n_degen++;
        if (out_if.qw !== e.qw) report_mismatch("qw", out_if.qw, e.qw);
        if (out_if.qx !== e.qx) report_mismatch("qx", out_if.qx, e.qx);
        if (out_if.qy !== e.qy) report_mismatch("qy", out_if.qy, e.qy);
        if (out_if.qz !== e.qz) report_mismatch("qz", out_if.qz, e.qz);
        if (out_if.degenerate !== e.degen)
          report_mismatch("degenerate", out_if.degenerate, e.degen);
      end
    end
  end

  initial begin
    n_errors = 0;
    n_checked = 0;
    n_degen = 0;
    cycles = 0;
    fork
      begin
        wait (stim_done);
        while (quat_fifo.size() != 0) @(posedge clk_i);
        // keep watching for stray results after the last expected one
        repeat (200) @(posedge clk_i);
      end
      begin
        while (cycles < CYCLE_LIMIT) begin
          @(posedge clk_i);
          cycles++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycles,
                 quat_fifo.size());
        $display("rotation_matrix_to_quaternion regression: fail");
        $finish;
      end
    join_any
    if (quat_fifo.size() != 0) report_mismatch("results left over", quat_fifo.size(), 0);
    $display("covered %0d matrices, %0d of them degenerate, over %0d cycles",
             n_checked, n_degen, cycles);
    if (n_errors == 0) begin
      $display("rotation_matrix_to_quaternion regression: pass");
    end else begin
      $display("rotation_matrix_to_quaternion regression: fail");
    end
    $finish;
  end

endmodule

// ===== rotation_matrix_to_quaternion.f =====
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rmq_front.sv
rtl/rmq_sqrt_cell.sv
rtl/rmq_div_cell.sv
rtl/rotation_matrix_to_quaternion.sv
tb/sv/rotation_matrix_to_quaternion_tb.sv
